/* rtl/capture_container_decoder_macros.svh */
// ----------------------------------------------------------------------------
// capture_container_decoder_macros
// Assertion macros shared by the capture container decoder.
// ----------------------------------------------------------------------------
`ifndef CAPTURE_CONTAINER_DECODER_MACROS_SVH
`define CAPTURE_CONTAINER_DECODER_MACROS_SVH

// same-cycle implication
`define CCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ccd_pkg.sv */
// ----------------------------------------------------------------------------
// ccd_pkg
// Types, constants and the magic table of the capture container decoder.
// ----------------------------------------------------------------------------
package ccd_pkg;

  localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

  localparam logic [5:0] HDR_LEN        = 6'd48;
  localparam logic [5:0] MAGIC_LEN      = 6'd8;
  localparam logic [5:0] SHORT_LIMIT    = 6'd51;
  localparam logic [5:0] POS_VERSION    = 6'd11;
  localparam logic [5:0] POS_FRAME      = 6'd19;
  localparam logic [5:0] POS_WIDTH      = 6'd23;
  localparam logic [5:0] POS_HEIGHT     = 6'd27;
  localparam logic [5:0] POS_PROD_WH    = 6'd28;
  localparam logic [5:0] POS_STRIDE     = 6'd31;
  localparam logic [5:0] POS_PROD_SH    = 6'd32;
  localparam logic [5:0] POS_PIXELS     = 6'd39;
  localparam logic [5:0] POS_DEPTH      = 6'd47;
  localparam logic [63:0] POS_LEN_SUM   = 64'd48;
  localparam logic [63:0] POS_LEN_NEED  = 64'd49;
  localparam logic [65:0] NEED_BIAS     = 66'd51;

  localparam int FLAG_MAGIC   = 0;
  localparam int FLAG_VERSION = 1;
  localparam int FLAG_HEADER  = 2;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_DEPTH  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_CHECKSUM = 3'd2,
    ERR_VERSION  = 3'd3,
    ERR_HEADER   = 3'd4,
    ERR_LENGTH   = 3'd5
  } err_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [31:0] payload_value;
    logic        capture_ok;
    err_t        error_code;
    logic [63:0] frame_id;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic [31:0] row_stride;
  } result_t;

  typedef struct packed {
    logic step;
    logic restart;
    logic active;
  } hash_ctl_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h41;
      3'd1: b = 8'h35;
      3'd2: b = 8'h31;
      3'd3: b = 8'h58;
      3'd4: b = 8'h52;
      3'd5: b = 8'h43;
      3'd6: b = 8'h41;
      3'd7: b = 8'h50;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/ccd_if.sv */
// ----------------------------------------------------------------------------
// ccd_if
// Valid/ready channels of the capture container decoder.
// ----------------------------------------------------------------------------
interface ccd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface ccd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] payload_value;
  logic        capture_ok;
  logic [2:0]  error_code;
  logic [63:0] frame_id;
  logic [31:0] frame_width;
  logic [31:0] frame_height;
  logic [31:0] row_stride;
  modport source (output valid, output result_kind, output payload_value,
                  output capture_ok, output error_code, output frame_id,
                  output frame_width, output frame_height, output row_stride,
                  input ready);
  modport sink (input valid, input result_kind, input payload_value,
                input capture_ok, input error_code, input frame_id,
                input frame_width, input frame_height, input row_stride,
                output ready);
endinterface

interface ccd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ccd_hash.sv */
// ----------------------------------------------------------------------------
// ccd_hash
// FNV-1a 32 running four bytes behind the stream, with the stored checksum
// compare against the last four bytes.
// ----------------------------------------------------------------------------
module ccd_hash
  import ccd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hash_ctl_t ctl,
  input  logic [7:0] data_byte,
  output logic      checksum_match
);

  logic [31:0] hash_r;
  logic [31:0] hash_nxt;
  logic [31:0] mixed;
  logic [7:0]  dly_r [4];

  assign mixed    = hash_r ^ {24'd0, dly_r[3]};
  assign hash_nxt = ctl.active ? mixed * FNV_PRIME : hash_r;
  assign checksum_match = ({data_byte, dly_r[0], dly_r[1], dly_r[2]} == hash_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_OFFSET;
      for (int i = 0; i < 4; i++) dly_r[i] <= 8'd0;
    end else if (ctl.step) begin
      if (ctl.restart) begin
        hash_r <= FNV_OFFSET;
        for (int i = 0; i < 4; i++) dly_r[i] <= 8'd0;
      end else begin
        hash_r   <= hash_nxt;
        dly_r[0] <= data_byte;
        dly_r[1] <= dly_r[0];
        dly_r[2] <= dly_r[1];
        dly_r[3] <= dly_r[2];
      end
    end
  end

endmodule

/* rtl/ccd_parser.sv */
// ----------------------------------------------------------------------------
// ccd_parser
// Header parse and checks, length precompute, payload region tracking and
// result formation for one byte per cycle while in_step is high.
// ----------------------------------------------------------------------------
module ccd_parser
  import ccd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_step,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic [31:0] expected_version,
  input  logic        checksum_match,
  output hash_ctl_t   hash_ctl,
  output result_t     res,
  output logic        res_valid
);

  logic [63:0] pos_r, pos_nxt;
  logic [63:0] fa_r, fa_nxt;
  logic [63:0] frame_r, frame_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] stride_r, stride_nxt;
  logic [63:0] pix_r, pix_nxt;
  logic [63:0] dep_r, dep_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [63:0] prod_wh_r, prod_wh_nxt;
  logic [63:0] prod_sh_r, prod_sh_nxt;
  logic [65:0] sum_r, sum_nxt;
  logic [63:0] need_r, need_nxt;
  logic        len_ovf_r, len_ovf_nxt;
  logic [63:0] pix_rem_r, pix_rem_nxt;
  logic [63:0] dep_rem_r, dep_rem_nxt;
  logic [1:0]  phase_r, phase_nxt;

  logic [5:0]  p6;
  logic        hdr_zone;
  logic        short_len;
  logic [63:0] fa_shift;
  logic        hdr_bad;
  logic [65:0] need_full;
  err_t        err;

  assign p6        = pos_r[5:0];
  assign hdr_zone  = (pos_r[63:6] == 58'd0) && (p6 < HDR_LEN);
  assign short_len = (pos_r[63:6] == 58'd0) && (p6 < SHORT_LIMIT);
  assign fa_shift  = {data_byte, fa_r[63:8]};
  assign need_full = sum_r + NEED_BIAS;

  assign hdr_bad = (width_r == 32'd0) || (height_r == 32'd0) ||
                   ({2'b00, stride_r} < {width_r, 2'b00}) ||
                   (fa_shift != prod_wh_r) || (pix_r != prod_sh_r) ||
                   (fa_shift[63:62] != 2'b00);

  assign hash_ctl.step    = in_step;
  assign hash_ctl.restart = final_byte;
  assign hash_ctl.active  = |pos_r[63:2];

  always_comb begin
    if (short_len || flags_r[FLAG_MAGIC]) begin
      err = ERR_SHORT;
    end else if (!checksum_match) begin
      err = ERR_CHECKSUM;
    end else if (flags_r[FLAG_VERSION]) begin
      err = ERR_VERSION;
    end else if (flags_r[FLAG_HEADER]) begin
      err = ERR_HEADER;
    end else if (len_ovf_r || (pos_r != need_r)) begin
      err = ERR_LENGTH;
    end else begin
      err = ERR_OK;
    end
  end

  always_comb begin
    pos_nxt     = (&pos_r) ? pos_r : pos_r + 64'd1;
    fa_nxt      = fa_r;
    frame_nxt   = frame_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    stride_nxt  = stride_r;
    pix_nxt     = pix_r;
    dep_nxt     = dep_r;
    flags_nxt   = flags_r;
    prod_wh_nxt = prod_wh_r;
    prod_sh_nxt = prod_sh_r;
    sum_nxt     = sum_r;
    need_nxt    = need_r;
    len_ovf_nxt = len_ovf_r;
    pix_rem_nxt = pix_rem_r;
    dep_rem_nxt = dep_rem_r;
    phase_nxt   = phase_r;
    res         = '0;
    res_valid   = 1'b0;

    if (hdr_zone) begin
      if (p6 < MAGIC_LEN) begin
        if (data_byte != magic_byte(p6[2:0])) flags_nxt[FLAG_MAGIC] = 1'b1;
      end else begin
        fa_nxt = fa_shift;
        case (p6)
          POS_VERSION: begin
            if (fa_shift[63:32] != expected_version) flags_nxt[FLAG_VERSION] = 1'b1;
          end
          POS_FRAME:   frame_nxt   = fa_shift;
          POS_WIDTH:   width_nxt   = fa_shift[63:32];
          POS_HEIGHT:  height_nxt  = fa_shift[63:32];
          POS_PROD_WH: prod_wh_nxt = {32'd0, width_r} * {32'd0, height_r};
          POS_STRIDE:  stride_nxt  = fa_shift[63:32];
          POS_PROD_SH: prod_sh_nxt = {32'd0, stride_r} * {32'd0, height_r};
          POS_PIXELS:  pix_nxt     = fa_shift;
          POS_DEPTH: begin
            dep_nxt     = fa_shift;
            pix_rem_nxt = pix_r;
            dep_rem_nxt = {fa_shift[61:0], 2'b00};
            phase_nxt   = 2'd0;
            if (hdr_bad) flags_nxt[FLAG_HEADER] = 1'b1;
          end
          default: ;
        endcase
      end
    end

    if (pos_r == POS_LEN_SUM) sum_nxt = {2'b00, pix_r} + {dep_r, 2'b00};
    if (pos_r == POS_LEN_NEED) begin
      need_nxt    = need_full[63:0];
      len_ovf_nxt = (need_full[65:64] != 2'b00) || (&need_full[63:0]);
    end

    if (final_byte) begin
      res_valid          = 1'b1;
      res.result_kind    = KIND_STATUS;
      res.error_code     = err;
      if (err == ERR_OK) begin
        res.capture_ok   = 1'b1;
        res.frame_id     = frame_r;
        res.frame_width  = width_r;
        res.frame_height = height_r;
        res.row_stride   = stride_r;
      end
      pos_nxt   = 64'd0;
      fa_nxt    = 64'd0;
      flags_nxt = 3'd0;
    end else if (!hdr_zone && (flags_r == 3'd0)) begin
      if (pix_rem_r != 64'd0) begin
        res_valid         = 1'b1;
        res.result_kind   = KIND_PIXEL;
        res.payload_value = {24'd0, data_byte};
        pix_rem_nxt       = pix_rem_r - 64'd1;
      end else if (dep_rem_r != 64'd0) begin
        fa_nxt      = fa_shift;
        dep_rem_nxt = dep_rem_r - 64'd1;
        phase_nxt   = phase_r + 2'd1;
        if (&phase_r) begin
          res_valid         = 1'b1;
          res.result_kind   = KIND_DEPTH;
          res.payload_value = fa_shift[63:32];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 64'd0;
      fa_r    <= 64'd0;
      flags_r <= 3'd0;
    end else if (in_step) begin
      pos_r   <= pos_nxt;
      fa_r    <= fa_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_step) begin
      frame_r   <= frame_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      stride_r  <= stride_nxt;
      pix_r     <= pix_nxt;
      dep_r     <= dep_nxt;
      prod_wh_r <= prod_wh_nxt;
      prod_sh_r <= prod_sh_nxt;
      sum_r     <= sum_nxt;
      need_r    <= need_nxt;
      len_ovf_r <= len_ovf_nxt;
      pix_rem_r <= pix_rem_nxt;
      dep_rem_r <= dep_rem_nxt;
      phase_r   <= phase_nxt;
    end
  end

endmodule

/* rtl/capture_container_decoder.sv */
// ----------------------------------------------------------------------------
// capture_container_decoder
// Streaming decoder for a checksummed capture container.
//
// in_ch carries one container byte per request, final_byte set on the last.
// out_ch carries pixel bytes and depth words once the header checks pass,
// and one status request per container on its last byte. On a status with
// capture_ok low, drop everything streamed for that container.
// cfg_ch writes expected_version (reset value 1); the user does so only while
// the block is idle, which the block does not enforce. A result is registered
// and appears the cycle after its byte is taken. One byte per cycle unless
// out_ch stalls; FNV multiply and header/length compares are combinational.
// The block takes a new byte while a result waits, as long as that result is
// taken in the same cycle; when the receiver stalls, in_ch.ready drops and the
// held result stays on out_ch. Reset clears the position, flags and hash and
// empties the output register; the next byte starts a fresh container.
// ----------------------------------------------------------------------------
`include "capture_container_decoder_macros.svh"

module capture_container_decoder
  import ccd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ccd_in_if.sink     in_ch,
  ccd_out_if.source  out_ch,
  ccd_cfg_if.sink    cfg_ch
);

  logic        in_accept;
  logic [31:0] version_r;
  logic        checksum_match;
  hash_ctl_t   hash_ctl;
  result_t     res;
  logic        res_valid;
  result_t     out_r;
  logic        out_valid_r;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 32'd1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      version_r <= cfg_ch.data;
    end
  end

  ccd_hash u_hash (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (hash_ctl),
    .data_byte      (in_ch.data_byte),
    .checksum_match (checksum_match)
  );

  ccd_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_step          (in_accept),
    .data_byte        (in_ch.data_byte),
    .final_byte       (in_ch.final_byte),
    .expected_version (version_r),
    .checksum_match   (checksum_match),
    .hash_ctl         (hash_ctl),
    .res              (res),
    .res_valid        (res_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) out_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_r.result_kind;
  assign out_ch.payload_value = out_r.payload_value;
  assign out_ch.capture_ok    = out_r.capture_ok;
  assign out_ch.error_code    = out_r.error_code;
  assign out_ch.frame_id      = out_r.frame_id;
  assign out_ch.frame_width   = out_r.frame_width;
  assign out_ch.frame_height  = out_r.frame_height;
  assign out_ch.row_stride    = out_r.row_stride;

  `CCD_ASSERT_NOW(a_ok_matches_code, clk, rst_n, out_valid_r && (out_r.result_kind == KIND_STATUS), out_r.capture_ok == (out_r.error_code == ERR_OK), "status ok flag disagrees with error code")
  `CCD_ASSERT_NEXT(a_final_gives_status, clk, rst_n, in_accept && in_ch.final_byte, out_valid_r && (out_r.result_kind == KIND_STATUS), "last byte did not produce a status")
  `CCD_ASSERT_NOW(a_bad_status_clear, clk, rst_n, out_valid_r && !out_r.capture_ok, (out_r.frame_id == 64'd0) && (out_r.frame_width == 32'd0) && (out_r.row_stride == 32'd0), "header fields leak on a failed or data result")

endmodule
